// ===== rtl/prlm_pkg.sv =====
`timescale 1ns / 1ps

package prlm_pkg;

    localparam int BUFFER_BLOCKS   = 32;
    localparam int POS_W           = 16;
    localparam int BLK_SHIFT       = $clog2(BUFFER_BLOCKS);
    localparam int QUO_W           = POS_W - BLK_SHIFT;
    localparam int BS_W            = 12;
    localparam int SIZE_W          = POS_W + 1;
    localparam int CNT_W           = 32;
    localparam int CMD_W           = 3;
    localparam int STEPS_PER_STAGE = 3;
    localparam int RED_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int RED_CNT_W       = $clog2(QUO_W + 1);
    localparam int IN_W            = 40;
    localparam int OUT_W           = 88;

    localparam logic [BS_W-1:0] BS_RESET = BS_W'(1024);

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_PAUSE  = 3'd4,
        CMD_RESUME = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        LVL_UNDER  = 2'd0,
        LVL_NORMAL = 2'd1,
        LVL_OVER   = 2'd2,
        LVL_STOP   = 2'd3
    } lvl_t;

    // one item on its way through the cursor and length reduction
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [QUO_W-1:0]     rq;
        logic [BLK_SHIFT-1:0] rlo;
        logic [BS_W-1:0]      rrem;
        logic [QUO_W-1:0]     wq;
        logic [BLK_SHIFT-1:0] wlo;
        logic [BS_W-1:0]      wrem;
    } stage_t;

    // one restoring step of a remainder by the block size
    function automatic logic [BS_W-1:0] mod_step(input logic [BS_W-1:0] r,
                                                 input logic            b,
                                                 input logic [BS_W-1:0] d);
        logic [BS_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) begin
            mod_step = BS_W'(t - {1'b0, d});
        end else begin
            mod_step = t[BS_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/playback_ring_level_monitor.sv =====
`timescale 1ns / 1ps

// channel   | valid / ready           | payload
// ----------+-------------------------+------------------------------------------
// s_        | s_tvalid / s_tready     | s_tdata: command, read_position, write_length
// m_        | m_tvalid / m_tready     | m_tdata: level state, pointers, counts, flags
// cfg_      | cfg_valid / cfg_ready   | cfg_data: block_size
//
// one transaction per cycle sustained while the result is not stalled and no reduction runs;
// an accepted input passes the input register, 4 stages reducing cursor and length
// modulo the buffer and the result register; a block_size write starts a reduction
// of the stored pointers (one quotient bit a cycle), during which s_tready is low;
// cfg_ready is always high; reset is synchronous; a stalled result holds the whole pipeline

module playback_ring_level_monitor (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command [2:0], read_position [18:3], write_length [34:19], zero [39:35]
    input  logic [prlm_pkg::IN_W-1:0]       s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // level_state [1:0], buffered_bytes [17:2], write_position [33:18],
    // played_bytes [65:34], start_play [66], stop_play [67], clear_buffer [68],
    // zero_fill [69], fill_start [85:70], write_refused [86], zero [87]
    output logic [prlm_pkg::OUT_W-1:0]      m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [prlm_pkg::BS_W-1:0]       cfg_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready
);

    localparam int N = prlm_pkg::RED_STAGES;
    localparam int PW = prlm_pkg::POS_W;
    localparam int SW = prlm_pkg::SIZE_W;
    localparam int BW = prlm_pkg::BS_W;
    localparam int QW = prlm_pkg::QUO_W;
    localparam int LW = prlm_pkg::BLK_SHIFT;

    logic [BW-1:0]             block_size_reg;
    logic [BW-1:0]             bs_eff;
    logic [SW-1:0]             size;

    prlm_pkg::lvl_t            level_state_reg, level_state_next;
    logic [PW-1:0]             write_pointer_reg, write_pointer_next;
    logic [PW-1:0]             last_read_reg, last_read_next;
    logic [prlm_pkg::CNT_W-1:0] played_count_reg, played_count_next;
    logic                      play_requested_reg, play_requested_next;
    logic                      buffer_empty_reg, buffer_empty_next;

    logic                      red_busy_reg;
    logic [prlm_pkg::RED_CNT_W-1:0] red_cnt_reg;
    logic [QW-1:0]             red_wq_reg, red_lq_reg;
    logic [BW-1:0]             red_wrem_reg, red_lrem_reg;
    logic [BW-1:0]             red_wrem_next, red_lrem_next;

    prlm_pkg::stage_t          pipe_reg [0:N];
    prlm_pkg::stage_t          step_out [1:N];
    logic                      valid_reg [0:N];

    logic                      adv;
    logic                      fire_out;
    logic [prlm_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic                      m_tvalid_reg;

    assign bs_eff = (block_size_reg == '0) ? BW'(1) : block_size_reg;
    assign size   = (bs_eff >= BW'(1 << QW)) ? SW'(1 << PW) : (SW'(bs_eff) << LW);

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv && !red_busy_reg;
    assign fire_out  = adv && valid_reg[N];
    assign cfg_ready = 1'b1;
    assign m_tdata   = m_tdata_reg;
    assign m_tvalid  = m_tvalid_reg;

    // reduction stages: remainder of the position bits above the block shift by block size
    always_comb begin
        prlm_pkg::stage_t st;
        for (int s = 1; s <= N; s++) begin
            st = pipe_reg[s-1];
            for (int j = 0; j < prlm_pkg::STEPS_PER_STAGE; j++) begin
                if ((s - 1) * prlm_pkg::STEPS_PER_STAGE + j < QW) begin
                    st.rrem = prlm_pkg::mod_step(st.rrem, st.rq[QW-1], bs_eff);
                    st.wrem = prlm_pkg::mod_step(st.wrem, st.wq[QW-1], bs_eff);
                    st.rq   = st.rq << 1;
                    st.wq   = st.wq << 1;
                end
            end
            step_out[s] = st;
        end
    end

    assign red_wrem_next = prlm_pkg::mod_step(red_wrem_reg, red_wq_reg[QW-1], bs_eff);
    assign red_lrem_next = prlm_pkg::mod_step(red_lrem_reg, red_lq_reg[QW-1], bs_eff);

    function automatic logic [SW-1:0] ring_dist(input logic [PW-1:0] from,
                                                input logic [PW-1:0] to,
                                                input logic [SW-1:0] sz);
        if (to >= from) begin
            ring_dist = {1'b0, to} - {1'b0, from};
        end else begin
            ring_dist = sz - {1'b0, from} + {1'b0, to};
        end
    endfunction

    always_comb begin
        logic [PW-1:0] rpos_r;
        logic [PW-1:0] wlen_r;
        logic [SW-1:0] buffered;
        logic [SW-1:0] trigger;
        logic [SW-1:0] zerofill;
        logic [SW-1:0] over_lvl;
        logic [SW-1:0] sum;
        logic          polled;
        logic          start, stop, clr, zf, refused;
        logic [PW-1:0] fstart;

        rpos_r   = {pipe_reg[N].rrem[QW-1:0], pipe_reg[N].rlo};
        wlen_r   = {pipe_reg[N].wrem[QW-1:0], pipe_reg[N].wlo};
        trigger  = SW'(bs_eff) + (SW'(bs_eff) << 1);
        zerofill = SW'(bs_eff) << 2;
        over_lvl = size - SW'(bs_eff);
        buffered = '0;
        sum      = '0;
        polled   = 1'b0;
        start    = 1'b0;
        stop     = 1'b0;
        clr      = 1'b0;
        zf       = 1'b0;
        refused  = 1'b0;
        fstart   = '0;

        level_state_next    = level_state_reg;
        write_pointer_next  = write_pointer_reg;
        last_read_next      = last_read_reg;
        played_count_next   = played_count_reg;
        play_requested_next = play_requested_reg;
        buffer_empty_next   = buffer_empty_reg;

        case (pipe_reg[N].cmd)
            prlm_pkg::CMD_POLL: begin
                polled   = 1'b1;
                buffered = ring_dist(rpos_r, write_pointer_reg, size);
                played_count_next = played_count_reg
                    + prlm_pkg::CNT_W'(ring_dist(last_read_reg, rpos_r, size));
                last_read_next = rpos_r;
                case (level_state_reg)
                    prlm_pkg::LVL_UNDER: begin
                        if (buffered > trigger) begin
                            level_state_next = (buffered >= size) ? prlm_pkg::LVL_OVER
                                                                  : prlm_pkg::LVL_NORMAL;
                            start = play_requested_reg && buffer_empty_reg;
                            buffer_empty_next = 1'b0;
                        end
                    end
                    prlm_pkg::LVL_NORMAL, prlm_pkg::LVL_OVER: begin
                        if (buffered < SW'(bs_eff)) begin
                            level_state_next = prlm_pkg::LVL_STOP;
                            zf     = 1'b1;
                            fstart = write_pointer_reg;
                            sum    = {1'b0, write_pointer_reg} + zerofill;
                            if (sum >= size) begin
                                sum = sum - size;
                            end
                            write_pointer_next = sum[PW-1:0];
                        end else if (buffered >= over_lvl) begin
                            level_state_next = prlm_pkg::LVL_OVER;
                        end else begin
                            level_state_next = prlm_pkg::LVL_NORMAL;
                        end
                    end
                    default: begin
                        if (buffered < zerofill) begin
                            stop = 1'b1;
                            clr  = 1'b1;
                            write_pointer_next = '0;
                            last_read_next     = '0;
                            level_state_next   = prlm_pkg::LVL_UNDER;
                            buffer_empty_next  = 1'b1;
                        end
                    end
                endcase
            end
            prlm_pkg::CMD_WRITE: begin
                if (level_state_reg == prlm_pkg::LVL_OVER ||
                    level_state_reg == prlm_pkg::LVL_STOP) begin
                    refused = 1'b1;
                end else begin
                    sum = {1'b0, write_pointer_reg} + {1'b0, wlen_r};
                    if (sum >= size) begin
                        sum = sum - size;
                    end
                    write_pointer_next = sum[PW-1:0];
                end
            end
            prlm_pkg::CMD_STOP, prlm_pkg::CMD_CLEAR: begin
                stop = (pipe_reg[N].cmd == prlm_pkg::CMD_STOP);
                clr  = 1'b1;
                write_pointer_next = '0;
                last_read_next     = '0;
                level_state_next   = prlm_pkg::LVL_UNDER;
                buffer_empty_next  = 1'b1;
            end
            prlm_pkg::CMD_PAUSE: begin
                stop = 1'b1;
                play_requested_next = 1'b0;
                buffer_empty_next   = 1'b0;
            end
            prlm_pkg::CMD_RESUME: begin
                play_requested_next = 1'b1;
                start = !buffer_empty_reg;
            end
            default: begin
            end
        endcase

        if (!polled) begin
            buffered = ring_dist(last_read_next, write_pointer_next, size);
        end

        m_tdata_next = {1'b0, refused, fstart, zf, clr, stop, start, played_count_next,
                        write_pointer_next, buffered[PW-1:0], level_state_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg     <= prlm_pkg::BS_RESET;
            level_state_reg    <= prlm_pkg::LVL_UNDER;
            write_pointer_reg  <= '0;
            last_read_reg      <= '0;
            played_count_reg   <= '0;
            play_requested_reg <= 1'b0;
            buffer_empty_reg   <= 1'b1;
            red_busy_reg       <= 1'b0;
            red_cnt_reg        <= '0;
            m_tvalid_reg       <= 1'b0;
            for (int s = 0; s <= N; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else begin
            if (cfg_valid) begin
                // restart the pointer reduction against the new block size
                block_size_reg <= cfg_data;
                red_busy_reg   <= 1'b1;
                red_cnt_reg    <= '0;
                red_wq_reg     <= write_pointer_reg[PW-1:LW];
                red_lq_reg     <= last_read_reg[PW-1:LW];
                red_wrem_reg   <= '0;
                red_lrem_reg   <= '0;
            end else if (red_busy_reg) begin
                red_wrem_reg <= red_wrem_next;
                red_lrem_reg <= red_lrem_next;
                red_wq_reg   <= red_wq_reg << 1;
                red_lq_reg   <= red_lq_reg << 1;
                red_cnt_reg  <= red_cnt_reg + 1'b1;
                if (red_cnt_reg == prlm_pkg::RED_CNT_W'(QW - 1)) begin
                    red_busy_reg      <= 1'b0;
                    write_pointer_reg <= {red_wrem_next[QW-1:0], write_pointer_reg[LW-1:0]};
                    last_read_reg     <= {red_lrem_next[QW-1:0], last_read_reg[LW-1:0]};
                end
            end

            if (adv) begin
                valid_reg[0] <= s_tvalid && s_tready;
                for (int s = 1; s <= N; s++) begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end

            if (fire_out) begin
                level_state_reg    <= level_state_next;
                write_pointer_reg  <= write_pointer_next;
                last_read_reg      <= last_read_next;
                played_count_reg   <= played_count_next;
                play_requested_reg <= play_requested_next;
                buffer_empty_reg   <= buffer_empty_next;
                m_tvalid_reg       <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg[0].cmd  <= s_tdata[prlm_pkg::CMD_W-1:0];
            pipe_reg[0].rq   <= s_tdata[prlm_pkg::CMD_W+PW-1:prlm_pkg::CMD_W+LW];
            pipe_reg[0].rlo  <= s_tdata[prlm_pkg::CMD_W+LW-1:prlm_pkg::CMD_W];
            pipe_reg[0].rrem <= '0;
            pipe_reg[0].wq   <= s_tdata[prlm_pkg::CMD_W+2*PW-1:prlm_pkg::CMD_W+PW+LW];
            pipe_reg[0].wlo  <= s_tdata[prlm_pkg::CMD_W+PW+LW-1:prlm_pkg::CMD_W+PW];
            pipe_reg[0].wrem <= '0;
            for (int s = 1; s <= N; s++) begin
                pipe_reg[s] <= step_out[s];
            end
        end
        if (fire_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule
